/* rtl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_RUN(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Check an implication on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pto_pkg.sv */
`default_nettype none

package pto_pkg;

  localparam int ACC_BITS         = 52;
  localparam int OUT_BITS         = 24;
  localparam int FFT_LEN_W        = 16;
  localparam logic [FFT_LEN_W-1:0] FFT_LEN_RESET = 16'd2048;

  localparam int SAMPLE_BITS_DEF  = 12;
  localparam int REF_BITS_DEF     = 8;
  localparam int FRAC_BITS_DEF    = 8;
  localparam int CORDIC_STEPS_DEF = 16;

  // Queue depth must stay a power of two: pointers wrap by overflow.
  localparam int QUEUE_DEPTH      = 4;
  localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [ACC_BITS-1:0] re;
    logic signed [ACC_BITS-1:0] im;
  } acc_pair_t;

  // atan(2^-i) in binary angle, 2^32 per full turn
  function automatic logic [31:0] atan_at(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/pilot_timing_offset_estimator.sv */
// Pilots are taken one per cycle; input stalls while four symbol ends are queued or in flight.
// From the last pilot to the result: front stages s1 and s2 to the queue, a queue read, a load,
// normalize shifts, CORDIC rotations (none for a zero sum), then multiply and round to scale.
// The back end sets the symbol rate: it takes a new symbol from the queue only when idle.
// Synchronous active-low reset clears pipeline valids, accumulator, queue and result valid;
// fft_length returns to 2048.
`default_nettype none

module pilot_timing_offset_estimator #(
  parameter int SAMPLE_BITS  = pto_pkg::SAMPLE_BITS_DEF,
  parameter int REF_BITS     = pto_pkg::REF_BITS_DEF,
  parameter int FRAC_BITS    = pto_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = pto_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [pto_pkg::FFT_LEN_W-1:0]      cfg_wr_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]      in_pilot_re,
  input  wire logic signed [SAMPLE_BITS-1:0]      in_pilot_im,
  input  wire logic signed [REF_BITS-1:0]         in_ref_re,
  input  wire logic signed [REF_BITS-1:0]         in_ref_im,
  input  wire logic                               in_last_pilot,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [pto_pkg::OUT_BITS-1:0]     out_offset_q8
);

  logic                       push, pop;
  pto_pkg::acc_pair_t         push_data, pop_data;
  logic [pto_pkg::QCNT_W-1:0] q_count;

  pto_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .REF_BITS    (REF_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pilot_re   (in_pilot_re),
    .in_pilot_im   (in_pilot_im),
    .in_ref_re     (in_ref_re),
    .in_ref_im     (in_ref_im),
    .in_last_pilot (in_last_pilot),
    .q_count       (q_count),
    .push          (push),
    .push_data     (push_data)
  );

  pto_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .count     (q_count)
  );

  pto_back #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .q_count       (q_count),
    .pop           (pop),
    .pop_data      (pop_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_offset_q8 (out_offset_q8)
  );

endmodule

`default_nettype wire

/* rtl/pto_front.sv */
`default_nettype none

module pto_front #(
  parameter int SAMPLE_BITS = pto_pkg::SAMPLE_BITS_DEF,
  parameter int REF_BITS    = pto_pkg::REF_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] in_pilot_re,
  input  wire logic signed [SAMPLE_BITS-1:0] in_pilot_im,
  input  wire logic signed [REF_BITS-1:0]    in_ref_re,
  input  wire logic signed [REF_BITS-1:0]    in_ref_im,
  input  wire logic                          in_last_pilot,
  input  wire logic [pto_pkg::QCNT_W-1:0]    q_count,
  output logic                               push,
  output pto_pkg::acc_pair_t                 push_data
);

  localparam int ZB = 2 * SAMPLE_BITS + 1;
  localparam int XB = 2 * REF_BITS + 1;
  localparam int TB = XB + ZB + 1;
  localparam int AB = pto_pkg::ACC_BITS;

  logic                          accept;
  logic                          have_prev_r;
  logic signed [SAMPLE_BITS-1:0] prev_pre_r, prev_pim_r;
  logic signed [REF_BITS-1:0]    prev_rre_r, prev_rim_r;

  logic signed [2*SAMPLE_BITS-1:0] m_rr, m_ii, m_ri, m_ir;
  logic signed [2*REF_BITS-1:0]    q_rr, q_ii, q_ri, q_ir;
  logic signed [ZB-1:0]            z_re_nxt, z_im_nxt;
  logic signed [XB-1:0]            x_re_nxt, x_im_nxt;

  logic                 s1_valid_r, s1_use_r, s1_last_r;
  logic signed [ZB-1:0] z_re_r, z_im_r;
  logic signed [XB-1:0] x_re_r, x_im_r;

  logic signed [XB+ZB-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [TB-1:0]    t_re_nxt, t_im_nxt;

  logic                 s2_valid_r, s2_use_r, s2_last_r;
  logic signed [TB-1:0] t_re_r, t_im_r;

  logic signed [AB-1:0] acc_re_r, acc_im_r;
  logic signed [AB-1:0] add_re, add_im, sum_re, sum_im;
  logic [pto_pkg::QCNT_W:0] credit;

  // Reserve a queue slot for every symbol end still in the pipeline.
  assign credit = {1'b0, q_count}
                + (pto_pkg::QCNT_W+1)'(s1_valid_r & s1_last_r)
                + (pto_pkg::QCNT_W+1)'(s2_valid_r & s2_last_r);
  assign in_ready = credit < (pto_pkg::QCNT_W+1)'(pto_pkg::QUEUE_DEPTH);
  assign accept   = in_valid & in_ready;

  // conj(prev) * cur for received and reference pilots
  assign m_rr = prev_pre_r * in_pilot_re;
  assign m_ii = prev_pim_r * in_pilot_im;
  assign m_ri = prev_pre_r * in_pilot_im;
  assign m_ir = prev_pim_r * in_pilot_re;
  assign z_re_nxt = ZB'(m_rr) + ZB'(m_ii);
  assign z_im_nxt = ZB'(m_ri) - ZB'(m_ir);

  assign q_rr = prev_rre_r * in_ref_re;
  assign q_ii = prev_rim_r * in_ref_im;
  assign q_ri = prev_rre_r * in_ref_im;
  assign q_ir = prev_rim_r * in_ref_re;
  assign x_re_nxt = XB'(q_rr) + XB'(q_ii);
  assign x_im_nxt = XB'(q_ri) - XB'(q_ir);

  // conj(x) * z
  assign p_rr = x_re_r * z_re_r;
  assign p_ii = x_im_r * z_im_r;
  assign p_ri = x_re_r * z_im_r;
  assign p_ir = x_im_r * z_re_r;
  assign t_re_nxt = TB'(p_rr) + TB'(p_ii);
  assign t_im_nxt = TB'(p_ri) - TB'(p_ir);

  assign add_re = s2_use_r ? AB'(t_re_r) : '0;
  assign add_im = s2_use_r ? AB'(t_im_r) : '0;
  assign sum_re = acc_re_r + add_re;
  assign sum_im = acc_im_r + add_im;

  assign push         = s2_valid_r & s2_last_r;
  assign push_data.re = sum_re;
  assign push_data.im = sum_im;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      acc_re_r    <= '0;
      acc_im_r    <= '0;
    end else begin
      s1_valid_r <= accept;
      s2_valid_r <= s1_valid_r;
      if (accept) begin
        have_prev_r <= ~in_last_pilot;
      end
      if (s2_valid_r) begin
        if (s2_last_r) begin
          acc_re_r <= '0;
          acc_im_r <= '0;
        end else begin
          acc_re_r <= sum_re;
          acc_im_r <= sum_im;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_pre_r <= in_pilot_re;
      prev_pim_r <= in_pilot_im;
      prev_rre_r <= in_ref_re;
      prev_rim_r <= in_ref_im;
      z_re_r     <= z_re_nxt;
      z_im_r     <= z_im_nxt;
      x_re_r     <= x_re_nxt;
      x_im_r     <= x_im_nxt;
      s1_use_r   <= have_prev_r;
      s1_last_r  <= in_last_pilot;
    end
    t_re_r    <= t_re_nxt;
    t_im_r    <= t_im_nxt;
    s2_use_r  <= s1_use_r;
    s2_last_r <= s1_last_r;
  end

endmodule

`default_nettype wire

/* rtl/pto_queue.sv */
`default_nettype none

module pto_queue (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire pto_pkg::acc_pair_t         push_data,
  input  wire logic                       pop,
  output pto_pkg::acc_pair_t              pop_data,
  output logic [pto_pkg::QCNT_W-1:0]      count
);

  pto_pkg::acc_pair_t mem [pto_pkg::QUEUE_DEPTH];

  logic [pto_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [pto_pkg::QCNT_W-1:0] count_r;
  pto_pkg::acc_pair_t         rd_data_r;

  assign count    = count_r;
  assign pop_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
    if (pop) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

endmodule

`default_nettype wire

/* rtl/pto_back.sv */
`default_nettype none

module pto_back #(
  parameter int FRAC_BITS    = pto_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = pto_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_wr_en,
  input  wire logic [pto_pkg::FFT_LEN_W-1:0]          cfg_wr_data,
  input  wire logic [pto_pkg::QCNT_W-1:0]             q_count,
  output logic                                        pop,
  input  wire pto_pkg::acc_pair_t                     pop_data,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [pto_pkg::OUT_BITS-1:0]         out_offset_q8
);

  localparam int AB  = pto_pkg::ACC_BITS;
  localparam int CW  = 34;
  localparam int ZW  = 34;
  localparam int AW  = 33;
  localparam int PW  = pto_pkg::FFT_LEN_W + 1 + AW;
  localparam int RW  = PW + 1;
  localparam int SH  = 32 - FRAC_BITS;
  localparam int SW  = $clog2(CORDIC_STEPS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_NORM = 3'd2;
  localparam logic [2:0] ST_ROT  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_RND  = 3'd5;

  localparam logic signed [AB-1:0] NORM_LIM = {{(AB-31){1'b0}}, 1'b1, 30'b0};
  localparam logic signed [ZW-1:0] Z_PI     = {{(ZW-32){1'b0}}, 1'b1, 31'b0};
  localparam logic signed [RW-1:0] HALF     = {{(RW-SH){1'b0}}, 1'b1, {(SH-1){1'b0}}};
  localparam logic signed [RW-1:0] OMAX     =
    (RW'(1) << (pto_pkg::OUT_BITS - 1)) - RW'(1);
  localparam logic signed [RW-1:0] OMIN     = -(RW'(1) << (pto_pkg::OUT_BITS - 1));

  logic [2:0]                      state_r;
  logic [pto_pkg::FFT_LEN_W-1:0]   fft_len_r;
  logic signed [AB-1:0]            x_r, y_r;
  logic signed [CW-1:0]            cx_r, cy_r;
  logic signed [ZW-1:0]            z_r;
  logic [SW-1:0]                   step_r;
  logic signed [PW-1:0]            prod_r;
  logic                            out_valid_r;
  logic signed [pto_pkg::OUT_BITS-1:0] out_offset_r;

  logic                 big;
  logic signed [CW-1:0] dx, dy;
  logic signed [ZW-1:0] atan_z, z_clamp;
  logic signed [AW-1:0] ang;
  logic signed [pto_pkg::FFT_LEN_W:0] fft_s;
  logic signed [PW-1:0] prod_nxt;
  logic signed [RW-1:0] rsum, rshift;
  logic signed [pto_pkg::OUT_BITS-1:0] off_sat;
  logic                 out_free;

  assign out_valid     = out_valid_r;
  assign out_offset_q8 = out_offset_r;
  assign out_free      = ~out_valid_r | out_ready;
  assign pop           = (state_r == ST_IDLE) && (q_count != '0);

  assign big = (x_r >= NORM_LIM) || (x_r <= -NORM_LIM) ||
               (y_r >= NORM_LIM) || (y_r <= -NORM_LIM);

  assign dx     = cy_r >>> step_r;
  assign dy     = cx_r >>> step_r;
  assign atan_z = signed'({{(ZW-32){1'b0}}, pto_pkg::atan_at(5'(step_r))});

  always_comb begin
    z_clamp = z_r;
    if (z_r > Z_PI) begin
      z_clamp = Z_PI;
    end else if (z_r < -Z_PI) begin
      z_clamp = -Z_PI;
    end
  end

  assign ang      = AW'(z_clamp);
  assign fft_s    = signed'({1'b0, fft_len_r});
  assign prod_nxt = fft_s * ang;

  // Round half up, then saturate to the output range.
  assign rsum   = RW'(prod_r) + HALF;
  assign rshift = rsum >>> SH;

  always_comb begin
    if (rshift > OMAX) begin
      off_sat = pto_pkg::OUT_BITS'(OMAX);
    end else if (rshift < OMIN) begin
      off_sat = pto_pkg::OUT_BITS'(OMIN);
    end else begin
      off_sat = pto_pkg::OUT_BITS'(rshift);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fft_len_r   <= pto_pkg::FFT_LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        fft_len_r <= cfg_wr_data;
      end
      if (out_valid_r && out_ready && state_r != ST_RND) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (pop) begin
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state_r <= ST_NORM;
        end
        ST_NORM: begin
          if (x_r == '0 && y_r == '0) begin
            state_r <= ST_MUL;
          end else if (!big) begin
            state_r <= ST_ROT;
          end
        end
        ST_ROT: begin
          if (step_r == SW'(CORDIC_STEPS - 1)) begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_r <= ST_RND;
        end
        ST_RND: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_LOAD: begin
        x_r <= pop_data.re;
        y_r <= pop_data.im;
      end
      ST_NORM: begin
        if (x_r == '0 && y_r == '0) begin
          z_r <= '0;
        end else if (big) begin
          x_r <= x_r >>> 1;
          y_r <= y_r >>> 1;
        end else begin
          // fold the left half plane onto the right, starting at +/- pi
          step_r <= '0;
          if (x_r[AB-1]) begin
            cx_r <= -CW'(x_r);
            cy_r <= -CW'(y_r);
            z_r  <= y_r[AB-1] ? -Z_PI : Z_PI;
          end else begin
            cx_r <= CW'(x_r);
            cy_r <= CW'(y_r);
            z_r  <= '0;
          end
        end
      end
      ST_ROT: begin
        step_r <= step_r + 1'b1;
        if (!cy_r[CW-1]) begin
          cx_r <= cx_r + dx;
          cy_r <= cy_r - dy;
          z_r  <= z_r + atan_z;
        end else begin
          cx_r <= cx_r - dx;
          cy_r <= cy_r + dy;
          z_r  <= z_r - atan_z;
        end
      end
      ST_MUL: begin
        prod_r <= prod_nxt;
      end
      ST_RND: begin
        if (out_free) begin
          out_offset_r <= off_sat;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/pto_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module pto_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic signed [pto_pkg::OUT_BITS-1:0] out_offset_q8
);

  // A result waiting on the sink stays put.
  `ASSERT_RUN(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result beat dropped")
  `ASSERT_RUN(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_offset_q8), "result beat changed under stall")

  // Reset leaves no result pending and, with the queue empty, the input ready.
  `ASSERT_ALWAYS(a_rst_out, clk, !rst_n, !out_valid, "result valid after reset")
  `ASSERT_ALWAYS(a_rst_ready, clk, !rst_n, in_ready, "input not ready after reset")

endmodule

bind pilot_timing_offset_estimator pto_checker u_pto_checker (.*);

`default_nettype wire

/* tb/tb_pilot_timing_offset_estimator.sv */
`timescale 1ns / 100ps

module tb_pilot_timing_offset_estimator;

  localparam int SB = pto_pkg::SAMPLE_BITS_DEF;
  localparam int RB = pto_pkg::REF_BITS_DEF;
  localparam int OB = pto_pkg::OUT_BITS;
  localparam int FW = pto_pkg::FFT_LEN_W;
  localparam int FRAC_BITS = pto_pkg::FRAC_BITS_DEF;
  localparam int ROTATIONS = pto_pkg::CORDIC_STEPS_DEF;
  localparam int ANGLE_SHIFT = 32 - FRAC_BITS;
  localparam int RESULT_LATENCY = 64;
  localparam int STALL_LIMIT = 3000;
  localparam int MAX_REPORTS = 10;

  localparam longint HALF_TURN = longint'(1) << 31;
  localparam longint NORM_LIMIT = longint'(1) << 30;
  localparam longint OFFSET_MAX = (longint'(1) << (OB - 1)) - 1;
  localparam longint OFFSET_MIN = -(longint'(1) << (OB - 1));

  // atan(2^-i) as a binary angle, 2^32 per turn
  localparam logic [31:0] ATAN_TURNS [0:15] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  typedef struct {
    logic signed [SB-1:0] rx_re;
    logic signed [SB-1:0] rx_im;
    logic signed [RB-1:0] ref_re;
    logic signed [RB-1:0] ref_im;
    logic                 last;
  } pilot_t;

  typedef enum int {MODE_FULL, MODE_SMALL, MODE_COHERENT, MODE_DEGENERATE} content_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [FW-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SB-1:0] in_pilot_re = '0;
  logic signed [SB-1:0] in_pilot_im = '0;
  logic signed [RB-1:0] in_ref_re = '0;
  logic signed [RB-1:0] in_ref_im = '0;
  logic in_last_pilot = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OB-1:0] out_offset_q8;

  pilot_timing_offset_estimator u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pilot_re   (in_pilot_re),
    .in_pilot_im   (in_pilot_im),
    .in_ref_re     (in_ref_re),
    .in_ref_im     (in_ref_im),
    .in_last_pilot (in_last_pilot),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_offset_q8 (out_offset_q8)
  );

  always #4 clk = ~clk;

  // Estimator state as seen from the ports
  logic [FW-1:0] fft_len_now = pto_pkg::FFT_LEN_RESET;
  logic signed [SB-1:0] prev_rx_re, prev_rx_im;
  logic signed [RB-1:0] prev_ref_re, prev_ref_im;
  logic signed [pto_pkg::ACC_BITS-1:0] sum_re, sum_im;
  logic have_prev;

  logic signed [OB-1:0] expected_offsets [$];
  logic signed [OB-1:0] oldest_offset;
  int mismatch_count = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  function automatic void clear_symbol();
    prev_rx_re = '0;
    prev_rx_im = '0;
    prev_ref_re = '0;
    prev_ref_im = '0;
    sum_re = '0;
    sum_im = '0;
    have_prev = 1'b0;
  endfunction

  function automatic longint vector_angle(input longint x, input longint y);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    while ((x < 0 ? -x : x) >= NORM_LIMIT || (y < 0 ? -y : y) >= NORM_LIMIT) begin
      x = x >>> 1;
      y = y >>> 1;
    end
    // fold the left half plane over, starting from +/- half a turn
    if (x < 0) begin
      z = (y >= 0) ? HALF_TURN : -HALF_TURN;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < ROTATIONS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_TURNS[i]);
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_TURNS[i]);
      end
    end
    if (z > HALF_TURN) z = HALF_TURN;
    if (z < -HALF_TURN) z = -HALF_TURN;
    return z;
  endfunction

  // Returns 1 when the pilot closes a symbol and yields an offset
  function automatic bit accumulate_pilot(input pilot_t p, output logic signed [OB-1:0] offset);
    longint zr, zi, xr, xi, ang, prod, off;
    offset = '0;
    if (have_prev) begin
      zr = longint'(prev_rx_re) * longint'(p.rx_re) + longint'(prev_rx_im) * longint'(p.rx_im);
      zi = longint'(prev_rx_re) * longint'(p.rx_im) - longint'(prev_rx_im) * longint'(p.rx_re);
      xr = longint'(prev_ref_re) * longint'(p.ref_re)
         + longint'(prev_ref_im) * longint'(p.ref_im);
      xi = longint'(prev_ref_re) * longint'(p.ref_im)
         - longint'(prev_ref_im) * longint'(p.ref_re);
      // wrap modulo the accumulator width
      sum_re = sum_re + (xr * zr + xi * zi);
      sum_im = sum_im + (xr * zi - xi * zr);
    end
    prev_rx_re = p.rx_re;
    prev_rx_im = p.rx_im;
    prev_ref_re = p.ref_re;
    prev_ref_im = p.ref_im;
    have_prev = 1'b1;
    if (!p.last) return 1'b0;
    ang = vector_angle(longint'(sum_re), longint'(sum_im));
    prod = longint'(fft_len_now) * ang;
    off = (prod + (longint'(1) << (ANGLE_SHIFT - 1))) >>> ANGLE_SHIFT;
    if (off > OFFSET_MAX) off = OFFSET_MAX;
    if (off < OFFSET_MIN) off = OFFSET_MIN;
    offset = off[OB-1:0];
    clear_symbol();
    return 1'b1;
  endfunction

  function automatic pilot_t pilot(input int re, input int im, input int rr, input int ri,
                                   input bit last);
    pilot_t p;
    p.rx_re = SB'(re);
    p.rx_im = SB'(im);
    p.ref_re = RB'(rr);
    p.ref_im = RB'(ri);
    p.last = last;
    return p;
  endfunction

  function automatic pilot_t random_pilot(input content_mode_t mode, input real ph);
    pilot_t p;
    real c, s;
    p.rx_re = SB'($urandom);
    p.rx_im = SB'($urandom);
    p.ref_re = RB'($urandom);
    p.ref_im = RB'($urandom);
    p.last = 1'b0;
    case (mode)
      MODE_SMALL: begin
        p.rx_re = SB'(int'($urandom_range(15)) - 8);
        p.rx_im = SB'(int'($urandom_range(15)) - 8);
      end
      MODE_COHERENT: begin
        // rotate the reference by the symbol's phase ramp, plus a little noise
        c = $cos(ph);
        s = $sin(ph);
        p.rx_re = SB'($rtoi(11.0 * (real'(p.ref_re) * c - real'(p.ref_im) * s))
                + int'($urandom_range(30)) - 15);
        p.rx_im = SB'($rtoi(11.0 * (real'(p.ref_re) * s + real'(p.ref_im) * c))
                + int'($urandom_range(30)) - 15);
      end
      MODE_DEGENERATE: begin
        if ($urandom_range(1)) begin
          p.ref_re = '0;
          p.ref_im = '0;
        end else begin
          p.rx_re = '0;
          p.rx_im = '0;
        end
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_pilot(input pilot_t p);
    logic signed [OB-1:0] offset;
    @(negedge clk);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid <= 1'b1;
    in_pilot_re <= p.rx_re;
    in_pilot_im <= p.rx_im;
    in_ref_re <= p.ref_re;
    in_ref_im <= p.ref_im;
    in_last_pilot <= p.last;
    do @(posedge clk); while (!in_ready);
    if (accumulate_pilot(p, offset)) expected_offsets.push_back(offset);
  endtask

  task automatic send_symbol(input int len, input content_mode_t mode);
    pilot_t p;
    real step;
    step = real'(int'($urandom_range(2000)) - 1000) / 1000.0 * 3.14159265;
    for (int k = 0; k < len; k++) begin
      p = random_pilot(mode, step * k);
      p.last = (k == len - 1);
      send_pilot(p);
    end
  endtask

  // Let every expected beat arrive, then give the pipeline time to go quiet
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_offsets.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY) @(posedge clk);
  endtask

  task automatic set_fft_length(input logic [FW-1:0] len);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    fft_len_now = len;
  endtask

  task automatic set_idling(input int src_pct, input int sink_pct);
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    send_pilot(pilot(2047, -2048, 127, -128, 1));
    send_pilot(pilot(0, 0, 0, 0, 0));
    send_pilot(pilot(0, 0, 0, 0, 1));
    send_pilot(pilot(-2048, -2048, -128, -128, 0));
    send_pilot(pilot(2047, 2047, 127, 127, 1));
    send_pilot(pilot(-2048, 2047, -128, 127, 0));
    send_pilot(pilot(2047, -2048, 127, -128, 1));
    // negative real sum, imag zero: angle starts at +half turn
    send_pilot(pilot(1000, 0, 64, 0, 0));
    send_pilot(pilot(-1000, 0, 64, 0, 1));
    send_pilot(pilot(1000, 0, 64, 0, 0));
    send_pilot(pilot(-1000, -10, 64, 0, 1));
    send_pilot(pilot(1000, 0, 64, 0, 0));
    send_pilot(pilot(0, 1000, 64, 0, 1));
    send_pilot(pilot(1000, 0, 64, 0, 0));
    send_pilot(pilot(0, -1000, 64, 0, 1));
    send_pilot(pilot(5, 3, 0, 0, 0));
    send_pilot(pilot(7, -2, 0, 0, 1));
    send_pilot(pilot(1, 0, 1, 0, 0));
    send_pilot(pilot(0, 1, 1, 0, 0));
    send_pilot(pilot(-1, 0, 1, 0, 1));
    drain();
  endtask

  task automatic test_fft_lengths();
    logic [FW-1:0] lens [0:5];
    lens = '{16'd0, 16'd64, 16'd32768, 16'd65535, 16'd0, pto_pkg::FFT_LEN_RESET};
    lens[4] = FW'($urandom_range(32768, 64));
    set_idling(0, 0);
    foreach (lens[i]) begin
      set_fft_length(lens[i]);
      send_symbol(1, MODE_FULL);
      send_symbol(4, MODE_COHERENT);
      send_symbol(3, MODE_FULL);
      send_symbol(6, MODE_COHERENT);
      drain();
    end
  endtask

  // Drive the accumulator far up so normalization takes many shifts
  task automatic test_large_sum();
    set_idling(0, 0);
    for (int k = 0; k < 160; k++) send_pilot(pilot(-2048, -2048, -128, -128, k == 159));
    for (int k = 0; k < 80; k++) send_pilot(pilot(2047, -2048, 127, -128, k == 79));
    drain();
  endtask

  task automatic test_backpressure();
    set_idling(0, 0);
    hold_request = 400;
    repeat (40) send_symbol(2, MODE_FULL);
    repeat (10) send_symbol(1, MODE_SMALL);
    drain();
  endtask

  task automatic test_random();
    int src_pcts [0:3];
    int sink_pcts [0:3];
    int sent, len, pick;
    content_mode_t mode;
    src_pcts = '{0, 65, 0, 9};
    sink_pcts = '{0, 0, 65, 9};
    for (int ph = 0; ph < 4; ph++) begin
      set_fft_length(FW'($urandom_range(32768, 64)));
      set_idling(src_pcts[ph], sink_pcts[ph]);
      sent = 0;
      while (sent < 280) begin
        pick = $urandom_range(99);
        len = (pick < 80) ? $urandom_range(12, 1) :
              (pick < 96) ? $urandom_range(64, 13) : $urandom_range(300, 65);
        pick = $urandom_range(99);
        mode = (pick < 40) ? MODE_COHERENT : (pick < 70) ? MODE_FULL :
               (pick < 85) ? MODE_SMALL : MODE_DEGENERATE;
        send_symbol(len, mode);
        sent += len;
      end
      drain();
    end
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic signed [OB-1:0] want,
                                 input logic signed [OB-1:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s: offset_q8 expected %0d, got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_offsets.size() == 0) begin
        report_mismatch("unexpected result beat", 'x, out_offset_q8);
      end else begin
        oldest_offset = expected_offsets.pop_front();
        if (out_offset_q8 !== oldest_offset)
          report_mismatch("offset mismatch", oldest_offset, out_offset_q8);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("pilot_timing_offset_estimator regression: fail");
    $finish;
  end

  initial begin
    clear_symbol();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_fft_lengths();
    test_large_sum();
    test_backpressure();
    test_random();
    if (mismatch_count == 0 && expected_offsets.size() == 0) begin
      $display("pilot_timing_offset_estimator regression: pass");
    end else begin
      $display("pilot_timing_offset_estimator regression: fail");
    end
    $finish;
  end

endmodule
